// File: design/ldls_pkg.sv
// ---------------------------------------------------------------------------
// ldls_pkg
// Shared constants and helpers for the linear discriminant log score core.
// ---------------------------------------------------------------------------
package ldls_pkg;

    // default fraction bits of all fixed point values
    localparam int FRAC_BITS_DEF = 16;

    // fraction bits of the internal log2 / ln values
    localparam int LOG_FB = 28;

    // ln(2) in Q28
    localparam longint LN2_Q28 = 64'd186065279;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 24;

    localparam logic [CFG_IW-1:0] REG_BIAS     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_XCORR    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_DELTA    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_RANK     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_MASSDIFF = 3'd4;
    localparam logic [CFG_IW-1:0] REG_LENCAP   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_FRAGS    = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_XCORR  = 2'd1;
    localparam logic [1:0] ST_LENGTH = 2'd2;
    localparam logic [1:0] ST_RANK   = 2'd3;

    // reset weights in thousandths
    localparam longint BIAS_MILLI     = 646;
    localparam longint XCORR_MILLI    = 5490;
    localparam longint DELTA_MILLI    = 4643;
    localparam longint RANK_MILLI     = -455;
    localparam longint MASSDIFF_MILLI = -840;

    localparam logic [9:0] LENCAP_RST = 10'd100;
    localparam logic [3:0] FRAGS_RST  = 4'd2;

    // thousandths to a saturated 24 bit weight, rounded half away from zero
    function automatic logic signed [23:0] milli_to_fix(input longint milli, input int fb);
        longint n;
        longint r;
        n = milli * (longint'(1) << fb);
        if (n >= 0)
            r = (n + 500) / 1000;
        else
            r = -((-n + 500) / 1000);
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return 24'(r);
    endfunction

endpackage

// File: design/linear_discriminant_log_score_core.sv
// ---------------------------------------------------------------------------
// linear_discriminant_log_score_core
// Pipelined linear discriminant score of one peptide match per item.
// ---------------------------------------------------------------------------
// One item enters every cycle while the output is not stalled. The pipeline has
// one input stage, a normalise stage, 28 squaring stages per log lane, an ln
// multiply stage, a divider of FRAC_BITS + 7 stages for the length
// normalisation, then product, sum and saturate stages. A stall at the output
// freezes the whole pipeline; items in flight are kept. Weights are taken from
// the register bank live, so write them only while no item is in flight.
module linear_discriminant_log_score_core #(
    parameter int FRAC_BITS = ldls_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [ldls_pkg::CFG_IW-1:0] cfg_index,
    input  logic [ldls_pkg::CFG_DW-1:0] cfg_wdata,
    // input items
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // xcorr[31:0], delta[63:32], rank_value[79:64], mass_difference[111:80],
    // residue_count[121:112], zero fill [127:122]
    input  logic [127:0]                s_axis_tdata,
    // result items
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // score[31:0]
    output logic [31:0]                 m_axis_tdata,
    // status[1:0]
    output logic [1:0]                  m_axis_tuser
);

    localparam int NSQ = ldls_pkg::LOG_FB;
    localparam int MW  = NSQ + 1;
    localparam int EW  = 7;
    localparam int LW  = EW + NSQ;
    localparam int QW  = FRAC_BITS + 6;
    localparam int CW  = LW - 1 + QW;
    localparam int AW  = 64;
    localparam int NL  = 3;
    localparam int XW  = 25 + QW;
    localparam int RPW = 24 + LW;

    localparam logic signed [NSQ:0]    LN2_S = (NSQ + 1)'(ldls_pkg::LN2_Q28);
    localparam logic signed [AW-1:0]   SMAX  = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0]   SMIN  = ~SMAX;
    localparam logic signed [EW-1:0]   FB_E  = EW'(FRAC_BITS);

    localparam logic signed [23:0] BIAS_RST  =
        ldls_pkg::milli_to_fix(ldls_pkg::BIAS_MILLI, FRAC_BITS);
    localparam logic signed [23:0] XCORR_RST =
        ldls_pkg::milli_to_fix(ldls_pkg::XCORR_MILLI, FRAC_BITS);
    localparam logic signed [23:0] DELTA_RST =
        ldls_pkg::milli_to_fix(ldls_pkg::DELTA_MILLI, FRAC_BITS);
    localparam logic signed [23:0] RANK_RST  =
        ldls_pkg::milli_to_fix(ldls_pkg::RANK_MILLI, FRAC_BITS);
    localparam logic signed [23:0] MASS_RST  =
        ldls_pkg::milli_to_fix(ldls_pkg::MASSDIFF_MILLI, FRAC_BITS);

    function automatic logic [4:0] msb_pos(input logic [31:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 32; i++)
            if (v[i])
                p = 5'(i);
        return p;
    endfunction

    // register bank
    logic signed [23:0] bias_weight_reg;
    logic signed [23:0] xcorr_weight_reg;
    logic signed [23:0] delta_weight_reg;
    logic signed [23:0] rank_weight_reg;
    logic signed [23:0] massdiff_weight_reg;
    logic [9:0]         length_cap_reg;
    logic [3:0]         fragment_count_reg;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_weight_reg     <= BIAS_RST;
            xcorr_weight_reg    <= XCORR_RST;
            delta_weight_reg    <= DELTA_RST;
            rank_weight_reg     <= RANK_RST;
            massdiff_weight_reg <= MASS_RST;
            length_cap_reg      <= ldls_pkg::LENCAP_RST;
            fragment_count_reg  <= ldls_pkg::FRAGS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ldls_pkg::REG_BIAS:     bias_weight_reg     <= $signed(cfg_wdata);
                ldls_pkg::REG_XCORR:    xcorr_weight_reg    <= $signed(cfg_wdata);
                ldls_pkg::REG_DELTA:    delta_weight_reg    <= $signed(cfg_wdata);
                ldls_pkg::REG_RANK:     rank_weight_reg     <= $signed(cfg_wdata);
                ldls_pkg::REG_MASSDIFF: massdiff_weight_reg <= $signed(cfg_wdata);
                ldls_pkg::REG_LENCAP:   length_cap_reg      <= cfg_wdata[9:0];
                ldls_pkg::REG_FRAGS:    fragment_count_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances when the output register is free or taken
    logic adv;
    logic out_vld_reg;
    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- input stage ----------------
    logic [31:0]        in_xcorr;
    logic signed [31:0] in_delta;
    logic [15:0]        in_rank;
    logic [31:0]        in_md;
    logic [9:0]         in_res;
    logic [9:0]         in_eff;
    logic [13:0]        in_prod;
    logic [31:0]        in_md_abs;
    logic [1:0]         in_status;

    assign in_xcorr  = s_axis_tdata[31:0];
    assign in_delta  = $signed(s_axis_tdata[63:32]);
    assign in_rank   = s_axis_tdata[79:64];
    assign in_md     = s_axis_tdata[111:80];
    assign in_res    = s_axis_tdata[121:112];
    assign in_eff    = (in_res < length_cap_reg) ? in_res : length_cap_reg;
    assign in_prod   = 14'(in_eff) * 14'(fragment_count_reg);
    assign in_md_abs = in_md[31] ? (~in_md + 32'd1) : in_md;

    // check in priority order: xcorr, length, rank
    always_comb
    begin
        if (in_xcorr[31] || in_xcorr == 32'd0)
            in_status = ldls_pkg::ST_XCORR;
        else if (in_prod <= 14'd1)
            in_status = ldls_pkg::ST_LENGTH;
        else if (in_rank == 16'd0)
            in_status = ldls_pkg::ST_RANK;
        else
            in_status = ldls_pkg::ST_OK;
    end

    logic               a_vld_reg;
    logic [31:0]        a_xcorr_reg;
    logic signed [31:0] a_delta_reg;
    logic [15:0]        a_rank_reg;
    logic [31:0]        a_md_reg;
    logic [13:0]        a_prod_reg;
    logic [1:0]         a_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_xcorr_reg <= in_xcorr;
            a_delta_reg <= in_delta;
            a_rank_reg  <= in_rank;
            a_md_reg    <= in_md_abs;
            a_prod_reg  <= in_prod;
            a_st_reg    <= in_status;
        end
    end

    // ---------------- normalise and squaring log2 lanes ----------------
    // lane 0 xcorr, lane 1 length product, lane 2 rank
    logic [31:0]        norm_v  [NL];
    logic signed [EW-1:0] norm_fb [NL];

    assign norm_v[0]  = a_xcorr_reg;
    assign norm_v[1]  = 32'(a_prod_reg);
    assign norm_v[2]  = 32'(a_rank_reg);
    assign norm_fb[0] = FB_E;
    assign norm_fb[1] = '0;
    assign norm_fb[2] = '0;

    logic [MW-1:0]        sq_m_reg [NL][0:NSQ];
    logic [NSQ-1:0]       sq_f_reg [NL][0:NSQ];
    logic signed [EW-1:0] sq_e_reg [NL][0:NSQ];
    logic                 sq_vld_reg   [0:NSQ];
    logic signed [31:0]   sq_delta_reg [0:NSQ];
    logic [31:0]          sq_md_reg    [0:NSQ];
    logic [1:0]           sq_st_reg    [0:NSQ];

    genvar k, l;
    generate
        for (k = 0; k <= NSQ; k++)
        begin : g_sq
            // carry side data and valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_vld_reg[k] <= 1'b0;
                else if (adv)
                    sq_vld_reg[k] <= (k == 0) ? a_vld_reg : sq_vld_reg[(k == 0) ? 0 : k - 1];
            end

            if (k == 0)
            begin : g_side0
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        sq_delta_reg[k] <= a_delta_reg;
                        sq_md_reg[k]    <= a_md_reg;
                        sq_st_reg[k]    <= a_st_reg;
                    end
                end
            end
            else
            begin : g_siden
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        sq_delta_reg[k] <= sq_delta_reg[k-1];
                        sq_md_reg[k]    <= sq_md_reg[k-1];
                        sq_st_reg[k]    <= sq_st_reg[k-1];
                    end
                end
            end

            for (l = 0; l < NL; l++)
            begin : g_lane
                if (k == 0)
                begin : g_norm
                    logic [4:0]  pos;
                    logic [31:0] shv;
                    assign pos = msb_pos(norm_v[l]);
                    assign shv = (pos >= 5'd28) ? (norm_v[l] >> (pos - 5'd28))
                                                : (norm_v[l] << (5'd28 - pos));
                    // bring the leading one to bit 28
                    always_ff @(posedge clk)
                    begin
                        if (adv)
                        begin
                            sq_m_reg[l][k] <= shv[MW-1:0];
                            sq_f_reg[l][k] <= '0;
                            sq_e_reg[l][k] <= $signed({2'b00, pos}) - norm_fb[l];
                        end
                    end
                end
                else
                begin : g_square
                    logic [2*MW-1:0] sq_p;
                    logic [MW:0]     sq_t;
                    assign sq_p = sq_m_reg[l][k-1] * sq_m_reg[l][k-1];
                    assign sq_t = sq_p[2*MW-1:NSQ];
                    // square, halve on overflow and record one fraction bit
                    always_ff @(posedge clk)
                    begin
                        if (adv)
                        begin
                            if (sq_t[MW])
                            begin
                                sq_m_reg[l][k] <= sq_t[MW:1];
                                sq_f_reg[l][k] <= sq_f_reg[l][k-1] | (NSQ'(1) << (NSQ - k));
                            end
                            else
                            begin
                                sq_m_reg[l][k] <= sq_t[MW-1:0];
                                sq_f_reg[l][k] <= sq_f_reg[l][k-1];
                            end
                            sq_e_reg[l][k] <= sq_e_reg[l][k-1];
                        end
                    end
                end
            end
        end
    endgenerate

    // ---------------- ln stage ----------------
    logic signed [LW-1:0] c_ln_reg [NL];
    logic                 c_vld_reg;
    logic signed [31:0]   c_delta_reg;
    logic [31:0]          c_md_reg;
    logic [1:0]           c_st_reg;

    generate
        for (l = 0; l < NL; l++)
        begin : g_ln
            logic signed [LW-1:0]    lg2;
            logic signed [LW+NSQ:0]  lnp;
            assign lg2 = $signed({sq_e_reg[l][NSQ], sq_f_reg[l][NSQ]});
            assign lnp = lg2 * LN2_S;
            // floor of log2 * ln2
            always_ff @(posedge clk)
            begin
                if (adv)
                    c_ln_reg[l] <= lnp[LW-1+NSQ:NSQ];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (adv)
            c_vld_reg <= sq_vld_reg[NSQ];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_delta_reg <= sq_delta_reg[NSQ];
            c_md_reg    <= sq_md_reg[NSQ];
            c_st_reg    <= sq_st_reg[NSQ];
        end
    end

    // ---------------- restoring divider, one quotient bit a stage ----------
    logic [CW-1:0]        dv_rem_reg   [0:QW];
    logic [QW-1:0]        dv_q_reg     [0:QW];
    logic [LW-2:0]        dv_dsr_reg   [0:QW];
    logic                 dv_neg_reg   [0:QW];
    logic signed [LW-1:0] dv_lnr_reg   [0:QW];
    logic                 dv_vld_reg   [0:QW];
    logic signed [31:0]   dv_delta_reg [0:QW];
    logic [31:0]          dv_md_reg    [0:QW];
    logic [1:0]           dv_st_reg    [0:QW];

    logic [LW-1:0] dv0_mag;
    assign dv0_mag = c_ln_reg[0][LW-1] ? LW'(-c_ln_reg[0]) : LW'(c_ln_reg[0]);

    genvar j;
    generate
        for (j = 0; j <= QW; j++)
        begin : g_div
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_vld_reg[j] <= 1'b0;
                else if (adv)
                    dv_vld_reg[j] <= (j == 0) ? c_vld_reg : dv_vld_reg[(j == 0) ? 0 : j - 1];
            end

            if (j == 0)
            begin : g_load
                // load magnitude of ln(xcorr) scaled by the fraction bits
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        dv_rem_reg[j]   <= CW'(dv0_mag[LW-2:0]) << FRAC_BITS;
                        dv_q_reg[j]     <= '0;
                        dv_dsr_reg[j]   <= c_ln_reg[1][LW-2:0];
                        dv_neg_reg[j]   <= c_ln_reg[0][LW-1];
                        dv_lnr_reg[j]   <= c_ln_reg[2];
                        dv_delta_reg[j] <= c_delta_reg;
                        dv_md_reg[j]    <= c_md_reg;
                        dv_st_reg[j]    <= c_st_reg;
                    end
                end
            end
            else
            begin : g_step
                logic [CW-1:0] trial;
                assign trial = CW'(dv_dsr_reg[j-1]) << (QW - j);
                // subtract the shifted divisor where it fits
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        if (dv_rem_reg[j-1] >= trial)
                        begin
                            dv_rem_reg[j] <= dv_rem_reg[j-1] - trial;
                            dv_q_reg[j]   <= dv_q_reg[j-1] | (QW'(1) << (QW - j));
                        end
                        else
                        begin
                            dv_rem_reg[j] <= dv_rem_reg[j-1];
                            dv_q_reg[j]   <= dv_q_reg[j-1];
                        end
                        dv_dsr_reg[j]   <= dv_dsr_reg[j-1];
                        dv_neg_reg[j]   <= dv_neg_reg[j-1];
                        dv_lnr_reg[j]   <= dv_lnr_reg[j-1];
                        dv_delta_reg[j] <= dv_delta_reg[j-1];
                        dv_md_reg[j]    <= dv_md_reg[j-1];
                        dv_st_reg[j]    <= dv_st_reg[j-1];
                    end
                end
            end
        end
    endgenerate

    // ---------------- product stage ----------------
    logic signed [QW:0]     ratio;
    logic signed [RPW-1:0]  rank_p;
    assign ratio  = dv_neg_reg[QW] ? -$signed({1'b0, dv_q_reg[QW]})
                                   :  $signed({1'b0, dv_q_reg[QW]});
    assign rank_p = rank_weight_reg * dv_lnr_reg[QW];

    logic signed [XW-1:0]  e_xt_reg;
    logic signed [55:0]    e_dt_reg;
    logic signed [RPW-1:0] e_rt_reg;
    logic signed [56:0]    e_mt_reg;
    logic [1:0]            e_st_reg;
    logic                  e_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (adv)
            e_vld_reg <= dv_vld_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_xt_reg <= xcorr_weight_reg * ratio;
            e_dt_reg <= delta_weight_reg * dv_delta_reg[QW];
            e_rt_reg <= rank_p >>> (NSQ - FRAC_BITS);
            e_mt_reg <= massdiff_weight_reg * $signed({1'b0, dv_md_reg[QW]});
            e_st_reg <= dv_st_reg[QW];
        end
    end

    // ---------------- sum stage ----------------
    logic signed [AW-1:0] f_acc_reg;
    logic [1:0]           f_st_reg;
    logic                 f_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (adv)
            f_vld_reg <= e_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_acc_reg <= (AW'(bias_weight_reg) <<< FRAC_BITS) + AW'(e_xt_reg)
                       + AW'(e_dt_reg) + AW'(e_rt_reg) + AW'(e_mt_reg);
            f_st_reg  <= e_st_reg;
        end
    end

    // ---------------- saturate and output register ----------------
    logic signed [AW-1:0] sh;
    logic [31:0]          score_next;
    assign sh = f_acc_reg >>> FRAC_BITS;

    always_comb
    begin
        if (f_st_reg != ldls_pkg::ST_OK)
            score_next = '0;
        else if (sh > SMAX)
            score_next = SMAX[31:0];
        else if (sh < SMIN)
            score_next = SMIN[31:0];
        else
            score_next = sh[31:0];
    end

    logic [31:0] out_score_reg;
    logic [1:0]  out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= f_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_score_reg <= score_next;
            out_st_reg    <= f_st_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_score_reg;
    assign m_axis_tuser  = out_st_reg;

`ifndef NO_ASSERTIONS
    // a failed check always carries a zero score
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ldls_pkg::ST_OK) |-> (m_axis_tdata == 32'd0))
        else $error("failed status with nonzero score");

    // divider leaves a remainder below the divisor for a valid item
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_vld_reg[QW] && dv_st_reg[QW] == ldls_pkg::ST_OK)
        |-> (dv_rem_reg[QW] < CW'(dv_dsr_reg[QW])))
        else $error("divider quotient overflow");

    // a stall freezes the pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |=> ($stable(sq_vld_reg[NSQ]) && $stable(f_vld_reg)
                            && $stable(e_xt_reg)))
        else $error("pipeline moved during stall");
`endif

endmodule
